/* rtl/core/bad_pkg.sv */
// Shared constants and register codes of the box average downscaler.
package bad_pkg;

	localparam int DEF_MAX_IMAGE_DIM = 4096;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W = 32;
	localparam int CHAN_W = 8;
	localparam int NUM_CHAN = 4;
	localparam int SUM_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXDIM = 2'd2;

endpackage

/* rtl/core/bad_pix_if.sv */
// Pixel stream channels: input pixels and averaged results.
interface bad_pix_if import bad_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface bad_avg_if import bad_pkg::*; ();
	logic valid;
	logic ready;
	logic [PIX_W-1:0] out_pixel;
	logic last_of_image;
	modport source (output valid, output out_pixel, output last_of_image, input ready);
	modport sink (input valid, input out_pixel, input last_of_image, output ready);
endinterface

/* rtl/core/bad_scale_div.sv */
// Restoring divider, one quotient bit per cycle, for the tile size.
module bad_scale_div import bad_pkg::*; #(
	parameter int NUM_W = 14,
	parameter int Q_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [CFG_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [CFG_W-1:0] den_q;
	logic [CFG_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [CFG_W:0]   trial;
	logic             ge;
	logic             fin_q;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge = trial >= {1'b0, den_q};
	assign done = fin_q;
	assign quo = num_q[Q_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? CFG_W'(trial - {1'b0, den_q}) : trial[CFG_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	// quotient is complete once the shift count runs out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q <= 1'b0;
		end else begin
			fin_q <= busy_q && (cnt_q == CNT_W'(1));
		end
	end
endmodule

/* rtl/core/bad_avg_div.sv */
// Four-lane divider that turns channel sums into saturated 8-bit averages.
module bad_avg_div import bad_pkg::*; #(
	parameter int N_W = 26
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_CHAN*SUM_W-1:0] sums,
	input  logic [N_W-1:0]            n,
	output logic                      done,
	output logic [PIX_W-1:0]          avg
);
	localparam int CW = (N_W + 9 > SUM_W + 1) ? N_W + 9 : SUM_W + 1;
	localparam int STEP_W = $clog2(CHAN_W);

	logic [CW-1:0]     rem_q [NUM_CHAN];
	logic [CHAN_W-1:0] quo_q [NUM_CHAN];
	logic              sat_q [NUM_CHAN];
	logic [N_W-1:0]    n_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     dvs;
	logic [CW-1:0]     lim;

	assign dvs = CW'(n_q) << step_q;
	assign lim = CW'(n) << CHAN_W;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(CHAN_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n;
		end
	end

	for (genvar l = 0; l < NUM_CHAN; l++) begin : g_lane
		logic [CW-1:0] sum_x;
		logic          ge;
		assign sum_x = CW'(sums[l*SUM_W +: SUM_W]);
		assign ge = rem_q[l] >= dvs;
		always_ff @(posedge clk) begin
			if (start) begin
				rem_q[l] <= sum_x;
				sat_q[l] <= sum_x >= lim;
				quo_q[l] <= '0;
			end else if (busy_q) begin
				if (ge) begin
					rem_q[l] <= rem_q[l] - dvs;
				end
				quo_q[l] <= {quo_q[l][CHAN_W-2:0], ge};
			end
		end
		assign avg[l*CHAN_W +: CHAN_W] = sat_q[l] ? {CHAN_W{1'b1}} : quo_q[l];
	end
endmodule

/* rtl/core/box_average_downscale.sv */
// Top level of the box average downscaler.
// Box average downscaler: takes ARGB pixels in raster order and emits one averaged pixel per
// scale-by-scale tile, the scale latched at each image's first pixel as the ceiling of the
// larger dimension over max_dimension (pass-through when that is zero or not exceeded). One
// item is handled at a time: a pixel that ends no tile passes through accept, column-sum
// memory read and read-modify-write; a pixel that ends a tile then also waits for the
// 8-step per-channel divider and for the output register to drain; the first pixel of an
// image first passes a scale state, which runs the scale divider when the image must
// shrink. Column sums live in one memory, one entry per output column.
module box_average_downscale import bad_pkg::*; #(
	parameter int MAX_IMAGE_DIM = DEF_MAX_IMAGE_DIM
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bad_pix_if.sink              pix_stream,
	bad_avg_if.source            avg_stream
);
	localparam int DIM_W = $clog2(MAX_IMAGE_DIM);
	localparam int EW = DIM_W + 1;
	localparam int XW = (CFG_W > EW) ? CFG_W : EW;
	localparam int NUM_W = XW + 1;
	localparam int N_W = 2 * EW;
	localparam int MW = NUM_CHAN * SUM_W;

	typedef enum logic [2:0] {S_IDLE, S_SCALE, S_SDIV, S_READ, S_MOD, S_DIV, S_OUT} state_t;

	state_t           state_q;
	logic [CFG_W-1:0] width_q, height_q, maxdim_q;
	logic [DIM_W-1:0] col_q, row_q, ocol_q;
	logic [EW-1:0]    offc_q, offr_q, scale_q;
	logic [PIX_W-1:0] pix_q;
	logic             last_q;
	logic [MW-1:0]    col_sum_mem [MAX_IMAGE_DIM];
	logic [MW-1:0]    rd_data_q;
	logic [MW-1:0]    new_sums;

	function automatic logic [EW-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [XW-1:0] vx;
		vx = XW'(v);
		if (v == '0) return EW'(1);
		if (vx > XW'(MAX_IMAGE_DIM)) return EW'(MAX_IMAGE_DIM);
		return vx[EW-1:0];
	endfunction

	logic [EW-1:0]    w_eff, h_eff, larger;
	logic             no_shrink;
	logic [NUM_W-1:0] sd_num;
	logic             sd_start, sd_done;
	logic [EW-1:0]    sd_quo;

	assign w_eff = eff_dim(width_q);
	assign h_eff = eff_dim(height_q);
	assign larger = (w_eff > h_eff) ? w_eff : h_eff;
	assign no_shrink = (maxdim_q == '0) || (XW'(larger) <= XW'(maxdim_q));
	assign sd_num = NUM_W'(larger) + NUM_W'(maxdim_q) - NUM_W'(1);
	assign sd_start = (state_q == S_SCALE) && !no_shrink;

	bad_scale_div #(.NUM_W(NUM_W), .Q_W(EW)) u_scale_div (
		.clk(clk), .arst_n(arst_n), .start(sd_start), .num(sd_num), .den(maxdim_q),
		.done(sd_done), .quo(sd_quo)
	);

	logic [EW-1:0]  col_p1, row_p1, offc_p1, offr_p1;
	logic           col_end, row_end, tile_end, first;
	logic [N_W-1:0] n_tile;
	logic           ad_start, ad_done;
	logic [PIX_W-1:0] ad_avg;

	assign col_p1 = EW'(col_q) + EW'(1);
	assign row_p1 = EW'(row_q) + EW'(1);
	assign offc_p1 = offc_q + EW'(1);
	assign offr_p1 = offr_q + EW'(1);
	assign col_end = col_p1 >= w_eff;
	assign row_end = row_p1 >= h_eff;
	assign tile_end = (col_end || offc_p1 >= scale_q) && (row_end || offr_p1 >= scale_q);
	assign first = (offc_q == '0) && (offr_q == '0);
	assign n_tile = N_W'(offc_p1) * N_W'(offr_p1);
	assign ad_start = (state_q == S_MOD) && tile_end;

	for (genvar l = 0; l < NUM_CHAN; l++) begin : g_sum
		logic [SUM_W-1:0] px;
		assign px = SUM_W'(pix_q[l*CHAN_W +: CHAN_W]);
		assign new_sums[l*SUM_W +: SUM_W] = first ? px : rd_data_q[l*SUM_W +: SUM_W] + px;
	end

	bad_avg_div #(.N_W(N_W)) u_avg_div (
		.clk(clk), .arst_n(arst_n), .start(ad_start), .sums(new_sums), .n(n_tile),
		.done(ad_done), .avg(ad_avg)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_MOD) begin
			col_sum_mem[ocol_q] <= new_sums;
		end
		rd_data_q <= col_sum_mem[ocol_q];
	end

	assign pix_stream.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1);
			height_q <= CFG_W'(1);
			maxdim_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH: width_q <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_MAXDIM: maxdim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pix_stream.valid && pix_stream.ready) begin
			pix_q <= pix_stream.pixel;
		end
		if (ad_start) begin
			last_q <= col_end && row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q <= '0;
			row_q <= '0;
			ocol_q <= '0;
			offc_q <= '0;
			offr_q <= '0;
			scale_q <= EW'(1);
			avg_stream.valid <= 1'b0;
			avg_stream.out_pixel <= '0;
			avg_stream.last_of_image <= 1'b0;
		end else begin
			if (avg_stream.valid && avg_stream.ready && state_q != S_OUT) begin
				avg_stream.valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pix_stream.valid) begin
						if (col_q == '0 && row_q == '0) begin
							offc_q <= '0;
							offr_q <= '0;
							ocol_q <= '0;
							state_q <= S_SCALE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_SCALE: begin
					if (no_shrink) begin
						scale_q <= EW'(1);
						state_q <= S_READ;
					end else begin
						state_q <= S_SDIV;
					end
				end
				S_SDIV: begin
					if (sd_done) begin
						scale_q <= sd_quo;
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_MOD;
				S_MOD: begin
					// advance raster and tile position
					if (col_end) begin
						col_q <= '0;
						offc_q <= '0;
						ocol_q <= '0;
						if (row_end) begin
							row_q <= '0;
							offr_q <= '0;
						end else begin
							row_q <= row_p1[DIM_W-1:0];
							offr_q <= (offr_p1 >= scale_q) ? '0 : offr_p1;
						end
					end else begin
						col_q <= col_p1[DIM_W-1:0];
						if (offc_p1 >= scale_q) begin
							offc_q <= '0;
							ocol_q <= ocol_q + DIM_W'(1);
						end else begin
							offc_q <= offc_p1;
						end
					end
					state_q <= tile_end ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					if (ad_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (!avg_stream.valid || avg_stream.ready) begin
						avg_stream.valid <= 1'b1;
						avg_stream.out_pixel <= ad_avg;
						avg_stream.last_of_image <= last_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/core/bad_checker.sv */
// Port-level checks of the box average downscaler, bound to the top level.
module bad_checker import bad_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PIX_W-1:0] out_pixel,
	input logic             last_of_image
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel) && $stable(last_of_image))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second pixel taken while one is in work");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no pixel in work");
endmodule

bind box_average_downscale bad_checker u_bad_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pix_stream.valid),
	.in_ready(pix_stream.ready),
	.out_valid(avg_stream.valid),
	.out_ready(avg_stream.ready),
	.out_pixel(avg_stream.out_pixel),
	.last_of_image(avg_stream.last_of_image)
);
